@@ rtl/core/fpalu_pkg.sv @@
package fpalu_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } alu_in_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic        domain_error;
    } alu_out_t;

    localparam logic signed [9:0] EXP_BIAS   = 10'sd127;
    localparam logic signed [9:0] ALIGN_MAX  = 10'sd27;
    localparam int                DIV_BITS   = 4;
    localparam logic [48:0]       MUL_RND    = 49'h40_0000;
    localparam logic [27:0]       ADD_RND    = 28'd4;

    // One in-flight operation. Fields that a command does not use simply ride along.
    typedef struct packed {
        cmd_t               cmd;
        logic               dom;
        logic               zero;
        logic signed [9:0]  exp;
        logic [26:0]        x;
        logic [26:0]        y;
        logic [47:0]        acc;
        logic [23:0]        rem;
        logic [23:0]        low;
        logic [23:0]        dvsr;
        logic [23:0]        quot;
    } pipe_t;

endpackage

@@ rtl/core/positive_float_alu_top.sv @@
// Reduced single-precision float unit for positive normal operands: add, subtract,
// multiply and divide, one operation accepted per clock when the result side keeps up.
// Every operation passes through all stages to the output register. The depth is set by
// the divider, a six-stage restoring array that resolves four quotient bits per stage;
// add, subtract and multiply ride the same stages.
// Each stage holds its item until the next stage has room, so bubbles are squeezed out
// and a stalled result never blocks the stages behind it from filling.
module positive_float_alu_top
    import fpalu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_ready,
    input  alu_in_t  op,
    output logic     res_valid,
    input  logic     res_ready,
    output alu_out_t res
);

    pipe_t    s_reg  [1:7];
    pipe_t    s_next [1:7];
    pipe_t    arith_out;
    pipe_t    norm_out;
    alu_out_t res_reg;
    alu_out_t res_next;
    logic [8:1] vld_reg;
    logic [8:1] vld_next;
    logic [8:1] rdy;

    fpalu_prep u_prep (.op(op), .p(s_next[1]));

    fpalu_arith    u_arith (.i(s_reg[1]), .o(arith_out));
    fpalu_div_step u_div2  (.i(arith_out), .o(s_next[2]));

    fpalu_norm     u_norm  (.i(s_reg[2]), .o(norm_out));
    fpalu_div_step u_div3  (.i(norm_out), .o(s_next[3]));

    for (genvar k = 4; k <= 7; k++)
    begin : g_div
        fpalu_div_step u_div (.i(s_reg[k-1]), .o(s_next[k]));
    end

    fpalu_round u_round (.i(s_reg[7]), .o(res_next));

    assign rdy[8] = !vld_reg[8] || res_ready;
    for (genvar k = 1; k <= 7; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        vld_next[1] = rdy[1] ? op_valid : vld_reg[1];
        for (int k = 2; k <= 8; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && op_valid)
        begin
            s_reg[1] <= s_next[1];
        end
        for (int k = 2; k <= 7; k++)
        begin
            if (rdy[k] && vld_reg[k-1])
            begin
                s_reg[k] <= s_next[k];
            end
        end
        if (rdy[8] && vld_reg[7])
        begin
            res_reg <= res_next;
        end
    end

    assign op_ready  = rdy[1];
    assign res_valid = vld_reg[8];
    assign res       = res_reg;

    a_dom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.domain_error |-> res.result_word == 32'd0)
        else $error("domain error with nonzero result");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !res_ready |-> !op_ready)
        else $error("input accepted into a full pipeline");

    a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> vld_reg[1])
        else $error("front stage refuses input while empty");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[7] && !rdy[7] |=> vld_reg[7] && vld_reg[8])
        else $error("stalled stage lost its item");

endmodule

@@ rtl/core/fpalu_prep.sv @@
module fpalu_prep
    import fpalu_pkg::*;
(
    input  alu_in_t op,
    output pipe_t   p
);

    logic [7:0]        ea;
    logic [7:0]        eb;
    logic [23:0]       ma;
    logic [23:0]       mb;
    logic [26:0]       ma3;
    logic [26:0]       mb3;
    logic signed [9:0] d;
    logic signed [9:0] nd;

    always_comb
    begin
        ea  = op.operand_a[30:23];
        eb  = op.operand_b[30:23];
        ma  = {1'b1, op.operand_a[22:0]};
        mb  = {1'b1, op.operand_b[22:0]};
        ma3 = {ma, 3'b000};
        mb3 = {mb, 3'b000};
        d   = $signed({2'b00, ea}) - $signed({2'b00, eb});
        nd  = -d;

        p      = '0;
        p.cmd  = op.command;
        // Divide numerator is (ma << 23) + (mb >> 1), which is a plain concatenation.
        p.dvsr = mb;
        p.rem  = {1'b0, ma[23:1]};
        p.low  = {ma[0], mb[23:1]};

        case (op.command)
            CMD_ADD:
            begin
                if (!d[9])
                begin
                    p.exp = $signed({2'b00, ea});
                    p.x   = ma3;
                    p.y   = (d > ALIGN_MAX) ? '0 : (mb3 >> d[4:0]);
                end
                else
                begin
                    p.exp = $signed({2'b00, eb});
                    p.y   = mb3;
                    p.x   = (nd > ALIGN_MAX) ? '0 : (ma3 >> nd[4:0]);
                end
            end
            CMD_SUB:
            begin
                p.exp = $signed({2'b00, ea});
                p.dom = (op.operand_b[30:0] > op.operand_a[30:0]);
                p.x   = ma3;
                p.y   = (d > ALIGN_MAX) ? '0 : (mb3 >> d[4:0]);
            end
            CMD_MUL:
            begin
                p.exp = $signed({2'b00, ea}) + $signed({2'b00, eb}) - EXP_BIAS;
                p.x   = {3'b000, ma};
                p.y   = {3'b000, mb};
            end
            default:
            begin
                p.exp = $signed({2'b00, ea}) - $signed({2'b00, eb}) + EXP_BIAS;
            end
        endcase
    end

endmodule

@@ rtl/core/fpalu_arith.sv @@
module fpalu_arith
    import fpalu_pkg::*;
(
    input  pipe_t i,
    output pipe_t o
);

    logic [47:0] prod;

    always_comb
    begin
        prod = i.x[23:0] * i.y[23:0];
        o    = i;
        case (i.cmd)
            CMD_ADD: o.acc = {20'b0, {1'b0, i.x} + {1'b0, i.y}};
            CMD_SUB:
            begin
                o.acc  = {21'b0, i.x - i.y};
                o.zero = (i.x == i.y);
            end
            CMD_MUL: o.acc = prod;
            default: o.acc = '0;
        endcase
    end

endmodule

@@ rtl/core/fpalu_norm.sv @@
module fpalu_norm
    import fpalu_pkg::*;
(
    input  pipe_t i,
    output pipe_t o
);

    logic [4:0] msb;
    logic [4:0] lz;
    logic [4:0] sh;

    always_comb
    begin
        msb = '0;
        for (int k = 0; k < 27; k++)
        begin
            if (i.acc[k])
            begin
                msb = 5'(k);
            end
        end
        lz = 5'd26 - msb;
        // Left normalization stops once the exponent reaches zero.
        sh = ($signed({5'b0, lz}) < i.exp) ? lz : i.exp[4:0];

        o = i;
        case (i.cmd)
            CMD_ADD:
            begin
                if (i.acc[27])
                begin
                    o.acc = i.acc >> 1;
                    o.exp = i.exp + 10'sd1;
                end
            end
            CMD_SUB:
            begin
                if (!i.zero)
                begin
                    o.acc = i.acc << sh;
                    o.exp = i.exp - $signed({5'b0, sh});
                end
            end
            CMD_MUL:
            begin
                if (!i.acc[47] && (i.exp > 10'sd0))
                begin
                    o.acc = i.acc << 1;
                    o.exp = i.exp - 10'sd1;
                end
            end
            default:
            begin
                o = i;
            end
        endcase
    end

endmodule

@@ rtl/core/fpalu_div_step.sv @@
module fpalu_div_step
    import fpalu_pkg::*;
(
    input  pipe_t i,
    output pipe_t o
);

    logic [24:0] rem2;

    // Restoring division, DIV_BITS quotient bits per pipeline stage.
    always_comb
    begin
        o    = i;
        rem2 = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            rem2  = {o.rem, o.low[23]};
            o.low = {o.low[22:0], 1'b0};
            if (rem2 >= {1'b0, o.dvsr})
            begin
                o.rem  = 24'(rem2 - {1'b0, o.dvsr});
                o.quot = {o.quot[22:0], 1'b1};
            end
            else
            begin
                o.rem  = rem2[23:0];
                o.quot = {o.quot[22:0], 1'b0};
            end
        end
    end

endmodule

@@ rtl/core/fpalu_round.sv @@
module fpalu_round
    import fpalu_pkg::*;
(
    input  pipe_t    i,
    output alu_out_t o
);

    logic [24:0]       r;
    logic [25:0]       rm;
    logic [23:0]       q;
    logic signed [9:0] e;

    always_comb
    begin
        r  = 25'((28'(i.acc[26:0]) + ADD_RND) >> 3);
        rm = 26'(({1'b0, i.acc} + MUL_RND) >> 23);
        q  = i.quot;
        e  = i.exp;
        o  = '0;
        case (i.cmd)
            CMD_ADD, CMD_SUB:
            begin
                if (r[24])
                begin
                    r = r >> 1;
                    e = e + 10'sd1;
                end
                if (i.dom)
                begin
                    o.domain_error = 1'b1;
                end
                else if (!i.zero)
                begin
                    o.result_word = {e[8:0], r[22:0]};
                end
            end
            CMD_MUL:
            begin
                if (rm[25] || rm[24])
                begin
                    rm = rm >> 1;
                    e  = e + 10'sd1;
                end
                o.result_word = {e[8:0], rm[22:0]};
            end
            default:
            begin
                if (!q[23] && (e > 10'sd0))
                begin
                    q = q << 1;
                    e = e - 10'sd1;
                end
                o.result_word = {e[8:0], q[22:0]};
            end
        endcase
    end

endmodule

@@ tb/sv/positive_float_alu_top_test.sv @@
module positive_float_alu_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fpalu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 830;
    localparam int QUIET_ITEMS = 150;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     op_valid;
    logic     op_ready;
    alu_in_t  op;
    logic     res_valid;
    logic     res_ready;
    alu_out_t res;

    alu_out_t expected_results[$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       idle_enable = 1'b1;
    int       recv_stall = 0;

    positive_float_alu_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] pack_word(int e, logic [31:0] frac);
        logic [31:0] ew;
        ew = e;
        return (ew << 23) | (frac & 32'h7F_FFFF);
    endfunction

    function automatic logic [31:0] mant_of(logic [31:0] w);
        return (w & 32'h7F_FFFF) | 32'h80_0000;
    endfunction

    function automatic int exp_of(logic [31:0] w);
        return int'(w[30:23]);
    endfunction

    function automatic logic [31:0] float_add(logic [31:0] a, logic [31:0] b);
        int          ea;
        int          eb;
        int          e;
        int          d;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] s;
        logic [31:0] r;
        ea = exp_of(a);
        eb = exp_of(b);
        d = ea - eb;
        ma = mant_of(a) << 3;
        mb = mant_of(b) << 3;
        if (d >= 0)
        begin
            e = ea;
            mb = (d > 27) ? 32'd0 : (mb >> d);
        end
        else
        begin
            e = eb;
            ma = (-d > 27) ? 32'd0 : (ma >> (-d));
        end
        s = ma + mb;
        while (s >= (32'd1 << 27))
        begin
            s = s >> 1;
            e++;
        end
        while (s < (32'd1 << 26) && e > 0)
        begin
            s = s << 1;
            e--;
        end
        r = (s + 32'd4) >> 3;
        if (r[24])
        begin
            r = r >> 1;
            e++;
        end
        return pack_word(e, r);
    endfunction

    // Magnitudes are already known to satisfy b <= a, so the shift is never negative.
    function automatic logic [31:0] float_sub(logic [31:0] a, logic [31:0] b);
        int          e;
        int          d;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] s;
        logic [31:0] r;
        e = exp_of(a);
        d = exp_of(a) - exp_of(b);
        ma = mant_of(a) << 3;
        mb = (d > 27) ? 32'd0 : ((mant_of(b) << 3) >> d);
        s = ma - mb;
        if (s == 32'd0)
            return 32'd0;
        while (s < (32'd1 << 26) && e > 0)
        begin
            s = s << 1;
            e--;
        end
        while (s >= (32'd1 << 27))
        begin
            s = s >> 1;
            e++;
        end
        r = (s + 32'd4) >> 3;
        if (r[24])
        begin
            r = r >> 1;
            e++;
        end
        return pack_word(e, r);
    endfunction

    function automatic logic [31:0] float_mul(logic [31:0] a, logic [31:0] b);
        int          e;
        logic [63:0] p;
        logic [63:0] r;
        e = exp_of(a) + exp_of(b) - 127;
        p = 64'(mant_of(a)) * 64'(mant_of(b));
        while (p >= (64'd1 << 48))
        begin
            p = p >> 1;
            e++;
        end
        while (p < (64'd1 << 47) && e > 0)
        begin
            p = p << 1;
            e--;
        end
        r = (p + (64'd1 << 22)) >> 23;
        if (r >= (64'd1 << 24))
        begin
            r = r >> 1;
            e++;
        end
        return pack_word(e, r[31:0]);
    endfunction

    function automatic logic [31:0] float_div(logic [31:0] a, logic [31:0] b);
        int          e;
        logic [63:0] mb;
        logic [63:0] q;
        e = exp_of(a) - exp_of(b) + 127;
        mb = 64'(mant_of(b));
        q = ((64'(mant_of(a)) << 23) + (mb >> 1)) / mb;
        while (q < (64'd1 << 23) && e > 0)
        begin
            q = q << 1;
            e--;
        end
        while (q >= (64'd1 << 24))
        begin
            q = q >> 1;
            e++;
        end
        return pack_word(e, q[31:0]);
    endfunction

    function automatic alu_out_t alu_predict(alu_in_t item);
        alu_out_t y;
        y.result_word = 32'd0;
        y.domain_error = 1'b0;
        case (item.command)
            CMD_ADD: y.result_word = float_add(item.operand_a, item.operand_b);
            CMD_SUB:
            begin
                if (item.operand_b[30:0] > item.operand_a[30:0])
                    y.domain_error = 1'b1;
                else
                    y.result_word = float_sub(item.operand_a, item.operand_b);
            end
            CMD_MUL: y.result_word = float_mul(item.operand_a, item.operand_b);
            default: y.result_word = float_div(item.operand_a, item.operand_b);
        endcase
        return y;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_op(cmd_t cmd, logic [31:0] a, logic [31:0] b);
        alu_in_t item;
        int      gap;
        item.command = cmd;
        item.operand_a = a;
        item.operand_b = b;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= item;
        op_valid <= 1'b1;
        do
            @(posedge clk);
        while (!op_ready);
        expected_results.push_back(alu_predict(item));
    endtask

    function automatic logic [31:0] make_float(int e, logic [22:0] frac);
        return {1'b0, 8'(e), frac};
    endfunction

    task automatic test_add_directed();
        send_op(CMD_ADD, 32'h3F80_0000, 32'h3F80_0000);
        send_op(CMD_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_op(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        send_op(CMD_ADD, 32'h7F80_0000, 32'h0000_0001);
        send_op(CMD_ADD, 32'h3F80_0000, 32'h3000_0000);
        send_op(CMD_ADD, 32'hBF80_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_sub_directed();
        send_op(CMD_SUB, 32'h4000_0000, 32'h3F80_0000);
        send_op(CMD_SUB, 32'h3F80_0000, 32'h4000_0000);
        send_op(CMD_SUB, 32'h4049_0FDB, 32'h4049_0FDB);
        // The sign bit does not take part in the magnitude comparison.
        send_op(CMD_SUB, 32'hC049_0FDB, 32'h4049_0FDB);
        send_op(CMD_SUB, 32'h3F80_0001, 32'h3F80_0000);
        send_op(CMD_SUB, 32'h0080_0001, 32'h0080_0000);
        send_op(CMD_SUB, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_mul_directed();
        send_op(CMD_MUL, 32'h3F80_0000, 32'h3F80_0000);
        send_op(CMD_MUL, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_op(CMD_MUL, 32'h0080_0000, 32'h0080_0000);
        send_op(CMD_MUL, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
        send_op(CMD_MUL, 32'hFFFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_div_directed();
        send_op(CMD_DIV, 32'h3F80_0000, 32'h4040_0000);
        send_op(CMD_DIV, 32'h7F7F_FFFF, 32'h0080_0000);
        send_op(CMD_DIV, 32'h0080_0000, 32'h7F7F_FFFF);
        send_op(CMD_DIV, 32'h3F80_0000, 32'h3FFF_FFFF);
        send_op(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_random_ops();
        cmd_t        cmd;
        logic [31:0] a;
        logic [31:0] b;
        int          ea;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                idle_enable = 1'b0;
            cmd = cmd_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                2, 3, 4:
                begin
                    // Close exponents exercise cancellation and rounding carries.
                    ea = $urandom_range(1, 254);
                    a = make_float(ea, 23'($urandom));
                    b = make_float(ea + $urandom_range(0, 2) - 1, 23'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        b[22:0] = a[22:0] ^ 23'(1 << $urandom_range(0, 22));
                end
                default:
                begin
                    a = make_float($urandom_range(1, 254), 23'($urandom));
                    b = make_float($urandom_range(1, 254), 23'($urandom));
                end
            endcase
            if (cmd == CMD_SUB && $urandom_range(0, 3) != 0 && b[30:0] > a[30:0])
            begin
                a = a ^ b;
                b = a ^ b;
                a = a ^ b;
            end
            send_op(cmd, a, b);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: checks each transfer and, while idle_enable is set, stalls in random bursts.
    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", res.result_word, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.result_word !== want.result_word)
                        report_mismatch("result_word", res.result_word, want.result_word);
                    if (res.domain_error !== want.domain_error)
                        report_mismatch("domain_error", 32'(res.domain_error),
                                        32'(want.domain_error));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                res_ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                recv_stall <= $urandom_range(0, 3);
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        op_valid = 1'b0;
        op = '0;
        res_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_add_directed();
        test_sub_directed();
        test_mul_directed();
        test_div_directed();
        test_random_ops();
        op_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ positive_float_alu_top.f @@
rtl/core/fpalu_pkg.sv
rtl/core/fpalu_prep.sv
rtl/core/fpalu_arith.sv
rtl/core/fpalu_norm.sv
rtl/core/fpalu_div_step.sv
rtl/core/fpalu_round.sv
rtl/core/positive_float_alu_top.sv
tb/sv/positive_float_alu_top_test.sv
